>>> rtl/min_max_stat_prune_macros.svh
// Assertion macros used by the checker file.
`ifndef MIN_MAX_STAT_PRUNE_MACROS_SVH
`define MIN_MAX_STAT_PRUNE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define MMSP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Implication checked in the cycle after the antecedent holds.
`define MMSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

>>> rtl/mmsp_pkg.sv
// ----------------------------------------------------------------------------
// mmsp_pkg
// Shared types, codes and float helpers for the min/max pruning block.
// ----------------------------------------------------------------------------
package mmsp_pkg;

   localparam logic [2:0] OP_EQ = 3'd0;
   localparam logic [2:0] OP_LT = 3'd1;
   localparam logic [2:0] OP_LE = 3'd2;
   localparam logic [2:0] OP_GT = 3'd3;
   localparam logic [2:0] OP_GE = 3'd4;
   localparam logic [2:0] OP_IS_NULL = 3'd5;
   localparam logic [2:0] OP_NOT_NULL = 3'd6;

   localparam logic [1:0] KIND_INT = 2'd1;
   localparam logic [1:0] KIND_DBL = 2'd2;

   localparam logic [3:0] CT_LONG = 4'd0;
   localparam logic [3:0] CT_INT = 4'd1;
   localparam logic [3:0] CT_DATE = 4'd2;
   localparam logic [3:0] CT_TIME = 4'd3;
   localparam logic [3:0] CT_TS = 4'd4;
   localparam logic [3:0] CT_TSTZ = 4'd5;
   localparam logic [3:0] CT_BOOL = 4'd6;
   localparam logic [3:0] CT_DOUBLE = 4'd7;
   localparam logic [3:0] CT_FLOAT = 4'd8;

   // Decoded request held in the queue between front and back.
   typedef struct packed {
      logic       pass_fixed;  // result known without a compare
      logic       use_cmp;
      logic [2:0] op;
      logic [63:0] pv;
      logic       have_lo;
      logic [63:0] lo;
      logic       have_hi;
      logic [63:0] hi;
      logic       last;
   } item_type;

   // Signed 64-bit integer to double, round to nearest even.
   function automatic logic [63:0] i64_to_f64(input logic [63:0] raw);
      logic        neg;
      logic [63:0] mag;
      logic [5:0]  msb;
      logic [63:0] norm;
      logic [52:0] mant;
      logic        g, st;
      logic [53:0] rnd;
      logic [10:0] ex;
      neg = raw[63];
      mag = neg ? (64'd0 - raw) : raw;
      msb = 6'd0;
      for (int i = 0; i < 64; i++) begin
         if (mag[i]) msb = 6'(i);
      end
      if (mag == 64'd0) return 64'd0;
      norm = mag << (6'd63 - msb);
      mant = norm[63:11];
      g = norm[10];
      st = |norm[9:0];
      rnd = {1'b0, mant} + 54'(g & (st | mant[0]));
      ex = 11'(1023) + 11'(msb);
      // Rounding carried into the next power of two.
      if (rnd[53]) begin
         ex = ex + 11'd1;
         return {neg, ex, 52'd0};
      end
      return {neg, ex, rnd[51:0]};
   endfunction

   // Single to double, exact.
   function automatic logic [63:0] f32_to_f64(input logic [31:0] f);
      logic [7:0]  e;
      logic [22:0] m;
      logic [4:0]  p;
      logic [22:0] nm;
      e = f[30:23];
      m = f[22:0];
      if (e == 8'hFF) return {f[31], 11'h7FF, m, 29'd0};
      if (e != 8'd0) return {f[31], 11'(e) + 11'd896, m, 29'd0};
      if (m == 23'd0) return {f[31], 63'd0};
      p = 5'd0;
      for (int i = 0; i < 23; i++) begin
         if (m[i]) p = 5'(i);
      end
      // The leading one shifts out; the bits below it form the fraction.
      nm = m << (5'd23 - p);
      return {f[31], 11'd874 + 11'(p), nm, 29'd0};
   endfunction

   function automatic logic is_nan(input logic [63:0] d);
      return (d[62:52] == 11'h7FF) && (d[51:0] != 52'd0);
   endfunction

   // a < b for non-NaN doubles.
   function automatic logic f_lt(input logic [63:0] a, input logic [63:0] b);
      logic az;
      az = (a[62:0] == 63'd0) && (b[62:0] == 63'd0);
      if (az) return 1'b0;
      if (a[63] != b[63]) return a[63];
      if (a[63]) return a[62:0] > b[62:0];
      return a[62:0] < b[62:0];
   endfunction

endpackage

>>> rtl/mmsp_front.sv
// ----------------------------------------------------------------------------
// mmsp_front
// Decodes one request: null tests, literal and bound conversion to double.
// ----------------------------------------------------------------------------
module mmsp_front import mmsp_pkg::*; (
   input  logic [2:0]  op,
   input  logic        stats_present,
   input  logic [1:0]  pred_kind,
   input  logic [63:0] pred_value,
   input  logic [3:0]  column_type,
   input  logic [63:0] lower_bytes,
   input  logic [7:0]  lo_len,
   input  logic [63:0] upper_bytes,
   input  logic [7:0]  hi_len,
   input  logic [62:0] nulls,
   input  logic [62:0] records,
   input  logic        last,
   output item_type    item
);

   logic [7:0] width;

   // Byte width of the column type; zero means undecodable.
   always_comb begin
      case (column_type)
         CT_LONG, CT_TIME, CT_TS, CT_TSTZ, CT_DOUBLE: width = 8'd8;
         CT_INT, CT_DATE, CT_FLOAT: width = 8'd4;
         CT_BOOL: width = 8'd1;
         default: width = 8'd0;
      endcase
   end

   function automatic logic [63:0] dec(input logic [63:0] b);
      case (column_type)
         CT_DOUBLE: return b;
         CT_FLOAT: return f32_to_f64(b[31:0]);
         CT_BOOL: return (b[7:0] != 8'd0) ? 64'h3FF0000000000000 : 64'd0;
         CT_INT, CT_DATE: return i64_to_f64({{32{b[31]}}, b[31:0]});
         default: return i64_to_f64(b);
      endcase
   endfunction

   // Classify the request and convert operands.
   always_comb begin
      item.last = last;
      item.op = op;
      item.pv = (pred_kind == KIND_INT) ? i64_to_f64(pred_value) : pred_value;
      item.lo = dec(lower_bytes);
      item.hi = dec(upper_bytes);
      item.have_lo = (width != 8'd0) && (lo_len == width) && !is_nan(item.lo);
      item.have_hi = (width != 8'd0) && (hi_len == width) && !is_nan(item.hi);
      item.use_cmp = 1'b0;
      item.pass_fixed = 1'b1;
      if (stats_present) begin
         if (op == OP_IS_NULL) begin
            item.pass_fixed = nulls != 63'd0;
         end else if (op == OP_NOT_NULL) begin
            item.pass_fixed = !(nulls != 63'd0 && records != 63'd0
                                && nulls >= records);
         end else if ((pred_kind == KIND_INT || pred_kind == KIND_DBL)
                      && !is_nan(item.pv)) begin
            item.use_cmp = 1'b1;
         end
      end
   end

endmodule

>>> rtl/mmsp_queue.sv
// ----------------------------------------------------------------------------
// mmsp_queue
// Two-entry queue of decoded requests between front and back.
// ----------------------------------------------------------------------------
module mmsp_queue import mmsp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output item_type out_item
);

   item_type   mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_ready = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_item = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   // Storage.
   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_item;
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

>>> rtl/mmsp_back.sv
// ----------------------------------------------------------------------------
// mmsp_back
// Compares, accumulates the pass bit and emits the verdict.
// ----------------------------------------------------------------------------
module mmsp_back import mmsp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output logic     out_may_match
);

   logic pass_ff, vld_ff, res_ff;
   logic lt_lo, gt_hi, eq_lo, eq_hi, ok, acc, take;

   assign lt_lo = f_lt(in_item.pv, in_item.lo);
   assign gt_hi = f_lt(in_item.hi, in_item.pv);
   assign eq_lo = !lt_lo && !f_lt(in_item.lo, in_item.pv);
   assign eq_hi = !gt_hi && !f_lt(in_item.pv, in_item.hi);
   assign in_ready = !vld_ff || out_ready;
   assign take = in_valid && in_ready;
   assign out_valid = vld_ff;
   assign out_may_match = res_ff;

   // Outcome of one comparison request.
   always_comb begin
      ok = 1'b1;
      if (!in_item.use_cmp) begin
         ok = in_item.pass_fixed;
      end else begin
         case (in_item.op)
            OP_EQ: ok = !((in_item.have_lo && lt_lo) || (in_item.have_hi && gt_hi));
            OP_LT: ok = !(in_item.have_lo && (lt_lo || eq_lo));
            OP_LE: ok = !(in_item.have_lo && lt_lo);
            OP_GT: ok = !(in_item.have_hi && (gt_hi || eq_hi));
            OP_GE: ok = !(in_item.have_hi && gt_hi);
            default: ok = 1'b1;
         endcase
      end
      acc = pass_ff && ok;
   end

   // Pass bit and verdict register.
   always_ff @(posedge clock) begin
      if (reset) begin
         pass_ff <= 1'b1;
         vld_ff <= 1'b0;
      end else begin
         if (take && in_item.last) vld_ff <= 1'b1;
         else if (out_ready) vld_ff <= 1'b0;
         if (take) begin
            pass_ff <= in_item.last ? 1'b1 : acc;
            if (in_item.last) res_ff <= acc;
         end
      end
   end

endmodule

>>> rtl/min_max_stat_prune.sv
// ----------------------------------------------------------------------------
// min_max_stat_prune
// Zone-map pruning: ANDs per-predicate outcomes and reports a file verdict.
// ----------------------------------------------------------------------------
// channel   direction  handshake            payload
// req_      in         req_valid/req_ready  predicate and file statistics
// rsp_      out        rsp_valid/rsp_ready  may_match, one per last request
//
// One request per cycle while req_ready is high. A last request is decoded into
// the two-entry queue, taken from it by the compare stage, and its verdict is
// registered there and shows on rsp_valid.
// Synchronous reset empties the queue and sets the pass bit.
// While a verdict waits on rsp_ready the compare stage stops; the queue takes
// up to two more requests before req_ready drops.
module min_max_stat_prune import mmsp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_op,
   input  logic        req_stats_present,
   input  logic [1:0]  req_pred_kind,
   input  logic [63:0] req_pred_value,
   input  logic [3:0]  req_column_type,
   input  logic [63:0] req_lower_bytes,
   input  logic [7:0]  req_lower_len,
   input  logic [63:0] req_upper_bytes,
   input  logic [7:0]  req_upper_len,
   input  logic [62:0] req_null_count,
   input  logic [62:0] req_record_count,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_may_match
);

   item_type dec_item, q_item;
   logic     q_valid, q_ready;

   mmsp_front u_front (
      .op(req_op), .stats_present(req_stats_present), .pred_kind(req_pred_kind),
      .pred_value(req_pred_value), .column_type(req_column_type),
      .lower_bytes(req_lower_bytes), .lo_len(req_lower_len),
      .upper_bytes(req_upper_bytes), .hi_len(req_upper_len),
      .nulls(req_null_count), .records(req_record_count),
      .last(req_last), .item(dec_item)
   );

   mmsp_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_ready(req_ready), .in_item(dec_item),
      .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
   );

   mmsp_back u_back (
      .clock(clock), .reset(reset),
      .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out_may_match(rsp_may_match)
   );

endmodule

>>> rtl/mmsp_checker.sv
// ----------------------------------------------------------------------------
// mmsp_checker
// Port-level checks for the pruning block.
// ----------------------------------------------------------------------------
`include "min_max_stat_prune_macros.svh"
module mmsp_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_may_match
);

   logic rsp_stall;

   assign rsp_stall = rsp_valid && !rsp_ready;

   // A pending response holds its value.
   `MMSP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_may_match))
   // No response shows just after reset is released.
   `MMSP_ASSERT_NEXT(a_rst_idle, clock, reset, $past(reset), !rsp_valid)
   // When a response rises, req_ready stays high unless it was already low.
   `MMSP_ASSERT_IMP(a_ready_first, clock, reset, $rose(rsp_valid), req_ready || $past(!req_ready))
   // A response never rises straight out of reset.
   `MMSP_ASSERT_IMP(a_rsp_src, clock, reset, $rose(rsp_valid), !$past(reset))

endmodule

bind min_max_stat_prune mmsp_checker u_checker (
   .clock(clock), .reset(reset), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_may_match(rsp_may_match)
);
